// ----- rtl/tga_pixel_stream_decoder_defines.svh -----
// Assertion macros used by the port-level checker of the TGA pixel stream decoder.
// Each macro expands to one labeled concurrent assertion that is disabled
// while reset is active.
`ifndef TGA_PIXEL_STREAM_DECODER_DEFINES_SVH
`define TGA_PIXEL_STREAM_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGA_PSD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tga_psd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TGA_PSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tga_psd assertion failed");

`endif

// ----- rtl/tga_psd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA pixel stream decoder package
// Shared types and constants: configuration register indexes, pixel format
// codes and the RGBA pixel structure.
// ----------------------------------------------------------------------------
package tga_psd_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_COMPRESSED_MODE = 2'd0,
        CFG_BYTES_PER_PIXEL = 2'd1,
        CFG_TOTAL_PIXELS    = 2'd2
    } cfg_index_t;

    // Stored pixel formats.
    localparam logic [2:0] BPP_555  = 3'd2;
    localparam logic [2:0] BPP_BGR  = 3'd3;
    localparam logic [2:0] BPP_BGRA = 3'd4;

    // Reset values of the configuration registers.
    localparam logic        RST_COMPRESSED_MODE = 1'b0;
    localparam logic [2:0]  RST_BYTES_PER_PIXEL = BPP_BGRA;
    localparam logic [31:0] RST_TOTAL_PIXELS    = 32'd1;

    localparam logic [7:0] COMP_FULL = 8'hff;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgba_t;

endpackage

// ----- rtl/tga_psd_pixel_unpack.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA pixel unpacker
// Turns the collected little-endian bytes of one stored pixel plus its final
// byte into an RGBA8 pixel for the configured format.
// ----------------------------------------------------------------------------
module tga_psd_pixel_unpack
(
    input  logic [2:0]          bytes_per_pixel,
    input  logic [23:0]         pixel_bytes,
    input  logic [7:0]          last_byte,
    output tga_psd_pkg::rgba_t  pixel
);

    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;

    assign b0 = pixel_bytes[7:0];
    assign b1 = pixel_bytes[15:8];
    assign b2 = pixel_bytes[23:16];

    always_comb
    begin
        unique case (bytes_per_pixel)
            tga_psd_pkg::BPP_555:
            begin
                // 5-5-5 in a little-endian 16-bit word, each channel widened by three bits.
                pixel.red   = {last_byte[6:2], 3'b000};
                pixel.green = {last_byte[1:0], b0[7:5], 3'b000};
                pixel.blue  = {b0[4:0], 3'b000};
                pixel.alpha = tga_psd_pkg::COMP_FULL;
            end
            tga_psd_pkg::BPP_BGR:
            begin
                pixel.red   = last_byte;
                pixel.green = b1;
                pixel.blue  = b0;
                pixel.alpha = tga_psd_pkg::COMP_FULL;
            end
            tga_psd_pkg::BPP_BGRA:
            begin
                pixel.red   = b2;
                pixel.green = b1;
                pixel.blue  = b0;
                pixel.alpha = last_byte;
            end
            default:
            begin
                // Unsupported formats decode to a fixed yellow marker pixel.
                pixel.red   = tga_psd_pkg::COMP_FULL;
                pixel.green = tga_psd_pkg::COMP_FULL;
                pixel.blue  = 8'h00;
                pixel.alpha = tga_psd_pkg::COMP_FULL;
            end
        endcase
    end

endmodule

// ----- rtl/tga_pixel_stream_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA pixel stream decoder
// Decodes the pixel data section of a TGA image, raw or run-length coded,
// into RGBA8 pixels with a repeat count.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream takes one byte of pixel data per word in tdata, with
// tuser set on the first byte of an image to restart decoding. The master
// stream gives one word per decoded pixel; a run packet gives its pixel once
// with the repeat count, clipped to the pixels left in the image. tlast marks
// the word that completes the last pixel of the image, after which bytes are
// dropped until the next tuser.
// Configuration (mode, bytes per pixel, pixel count) is written through the
// cfg channel while the stream is idle; cfg_ready is always high. A new pixel
// count takes effect at the next image start; mode and format are used live.
// Timing: one byte is accepted every cycle while no pixel word is stalled. A
// pixel appears on the master side in the cycle after its last byte is accepted,
// from one output register. While a word waits there and the receiver stalls,
// s_axis_tready is low whatever the next byte is, so header and inner pixel
// bytes wait as well until the word is taken. s_axis_tready follows
// m_axis_tready directly, so a word taken in a cycle frees room for a byte
// in the same cycle.
// Reset clears the decoding state, sets the configuration to uncompressed,
// four bytes per pixel and one pixel, and empties the output register.
// ----------------------------------------------------------------------------
module tga_pixel_stream_decoder
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,

    // Byte input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] start_image

    // Pixel output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                        // [31:24] alpha, [39:32] repeat_count
    output logic        m_axis_tlast    // image_done
);

    // Configuration registers.
    logic        compressed_mode_reg;
    logic [2:0]  bytes_per_pixel_reg;
    logic [31:0] total_pixels_reg;

    // Decoding state.
    logic        expect_header_reg, expect_header_next;
    logic [1:0]  byte_position_reg, byte_position_next;
    logic [23:0] pixel_bytes_reg, pixel_bytes_next;
    logic [7:0]  packet_left_reg, packet_left_next;
    logic        packet_is_run_reg, packet_is_run_next;
    logic [31:0] pixels_remaining_reg, pixels_remaining_next;

    // Output register.
    logic        m_valid_reg;
    logic [39:0] m_data_reg, m_data_next;
    logic        m_last_reg, m_last_next;

    // State as seen by the current byte, after an optional restart.
    logic        cur_expect_header;
    logic [1:0]  cur_byte_position;
    logic [23:0] cur_pixel_bytes;
    logic [7:0]  cur_packet_left;
    logic        cur_packet_is_run;
    logic [31:0] cur_pixels_remaining;

    logic        in_accept;
    logic        emit;
    logic [2:0]  pixel_size;
    logic [7:0]  data_byte;
    logic [7:0]  run_count;
    logic [7:0]  count;
    tga_psd_pkg::rgba_t pixel;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = ~m_valid_reg | m_axis_tready;
    assign in_accept     = s_axis_tvalid & s_axis_tready;
    assign data_byte     = s_axis_tdata;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compressed_mode_reg <= tga_psd_pkg::RST_COMPRESSED_MODE;
            bytes_per_pixel_reg <= tga_psd_pkg::RST_BYTES_PER_PIXEL;
            total_pixels_reg    <= tga_psd_pkg::RST_TOTAL_PIXELS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tga_psd_pkg::CFG_COMPRESSED_MODE: compressed_mode_reg <= cfg_data[0];
                tga_psd_pkg::CFG_BYTES_PER_PIXEL: bytes_per_pixel_reg <= cfg_data[2:0];
                tga_psd_pkg::CFG_TOTAL_PIXELS:    total_pixels_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // A start byte sees freshly restarted state built from the live configuration.
    always_comb
    begin
        if (s_axis_tuser)
        begin
            cur_expect_header    = compressed_mode_reg;
            cur_byte_position    = 2'd0;
            cur_pixel_bytes      = 24'd0;
            cur_packet_left      = 8'd0;
            cur_packet_is_run    = 1'b0;
            cur_pixels_remaining = total_pixels_reg;
        end
        else
        begin
            cur_expect_header    = expect_header_reg;
            cur_byte_position    = byte_position_reg;
            cur_pixel_bytes      = pixel_bytes_reg;
            cur_packet_left      = packet_left_reg;
            cur_packet_is_run    = packet_is_run_reg;
            cur_pixels_remaining = pixels_remaining_reg;
        end
    end

    // Unsupported formats take one byte per pixel.
    assign pixel_size = (bytes_per_pixel_reg >= tga_psd_pkg::BPP_555 &&
                         bytes_per_pixel_reg <= tga_psd_pkg::BPP_BGRA) ?
                        bytes_per_pixel_reg : 3'd1;

    tga_psd_pixel_unpack u_unpack
    (
        .bytes_per_pixel (bytes_per_pixel_reg),
        .pixel_bytes     (cur_pixel_bytes),
        .last_byte       (data_byte),
        .pixel           (pixel)
    );

    // A run is clipped to the pixels that are still left in the image.
    assign run_count = (cur_pixels_remaining < {24'd0, cur_packet_left}) ?
                       cur_pixels_remaining[7:0] : cur_packet_left;

    always_comb
    begin
        expect_header_next    = cur_expect_header;
        byte_position_next    = cur_byte_position;
        pixel_bytes_next      = cur_pixel_bytes;
        packet_left_next      = cur_packet_left;
        packet_is_run_next    = cur_packet_is_run;
        pixels_remaining_next = cur_pixels_remaining;
        emit                  = 1'b0;
        count                 = 8'd1;

        if (cur_pixels_remaining == 32'd0)
        begin
            // Image complete: the byte is dropped.
        end
        else if (compressed_mode_reg && (cur_expect_header || cur_packet_left == 8'd0))
        begin
            // Packet header: low seven bits hold the count minus one, top bit the run flag.
            packet_left_next   = {1'b0, data_byte[6:0]} + 8'd1;
            packet_is_run_next = data_byte[7];
            expect_header_next = 1'b0;
            byte_position_next = 2'd0;
            pixel_bytes_next   = 24'd0;
        end
        else if ({1'b0, cur_byte_position} + 3'd1 < pixel_size)
        begin
            case (cur_byte_position)
                2'd0:    pixel_bytes_next[7:0]   = data_byte;
                2'd1:    pixel_bytes_next[15:8]  = data_byte;
                2'd2:    pixel_bytes_next[23:16] = data_byte;
                default: pixel_bytes_next        = cur_pixel_bytes;
            endcase
            byte_position_next = cur_byte_position + 2'd1;
        end
        else
        begin
            emit = 1'b1;
            if (compressed_mode_reg)
            begin
                if (cur_packet_is_run)
                begin
                    count            = run_count;
                    packet_left_next = 8'd0;
                end
                else
                begin
                    packet_left_next = cur_packet_left - 8'd1;
                end
                if (packet_left_next == 8'd0)
                begin
                    expect_header_next = 1'b1;
                end
            end
            pixels_remaining_next = cur_pixels_remaining - {24'd0, count};
            byte_position_next    = 2'd0;
            pixel_bytes_next      = 24'd0;
        end
    end

    assign m_data_next = {count, pixel.alpha, pixel.blue, pixel.green, pixel.red};
    assign m_last_next = (pixels_remaining_next == 32'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_header_reg    <= tga_psd_pkg::RST_COMPRESSED_MODE;
            byte_position_reg    <= 2'd0;
            pixel_bytes_reg      <= 24'd0;
            packet_left_reg      <= 8'd0;
            packet_is_run_reg    <= 1'b0;
            pixels_remaining_reg <= tga_psd_pkg::RST_TOTAL_PIXELS;
        end
        else if (in_accept)
        begin
            expect_header_reg    <= expect_header_next;
            byte_position_reg    <= byte_position_next;
            pixel_bytes_reg      <= pixel_bytes_next;
            packet_left_reg      <= packet_left_next;
            packet_is_run_reg    <= packet_is_run_next;
            pixels_remaining_reg <= pixels_remaining_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (in_accept && emit)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && emit)
        begin
            m_data_reg <= m_data_next;
            m_last_reg <= m_last_next;
        end
    end

endmodule

// ----- rtl/tga_psd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA pixel stream decoder checker
// Port-level assertions on the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "tga_pixel_stream_decoder_defines.svh"

module tga_psd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A stalled pixel word stays valid and unchanged.
    `TGA_PSD_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // No byte is taken while a stalled pixel occupies the output register.
    `TGA_PSD_ASSERT_SAME(a_no_accept_when_full, clk, rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready)

    // Every pixel word carries a repeat count from one to one hundred twenty-eight.
    `TGA_PSD_ASSERT_SAME(a_count_range, clk, rst_n, m_axis_tvalid, m_axis_tdata[39:32] != 8'd0 && m_axis_tdata[39:32] <= 8'd128)

endmodule

bind tga_pixel_stream_decoder tga_psd_checker u_tga_psd_checker (.*);

// ----- sim/tga_pixel_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA pixel stream decoder checker
// Watches the configuration, byte and pixel channels, predicts each pixel
// word from the accepted bytes, and compares every pixel word field by field.
// ----------------------------------------------------------------------------
module tga_pixel_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic        end_of_run,
    output int          pending,
    output int          fail_count
);

    typedef struct packed {
        tga_psd_pkg::rgba_t px;
        logic [7:0]         repeat_count;
        logic               image_done;
    } pixel_word_t;

    // Register values as the decoder sees them.
    logic        cur_compressed;
    logic [2:0]  cur_bpp;
    logic [31:0] cur_total;

    // Decoding state.
    logic        want_header;
    logic [1:0]  byte_pos;
    logic [23:0] held_bytes;
    logic [7:0]  packet_left;
    logic        packet_run;
    logic [31:0] pixels_left;

    pixel_word_t expected_pixels[$];
    bit          leftovers_checked;

    function void restart_image();
        want_header = cur_compressed;
        byte_pos = '0;
        held_bytes = '0;
        packet_left = '0;
        packet_run = 1'b0;
        pixels_left = cur_total;
    endfunction

    // Advances the decoding state by one byte; returns 1 when a pixel completes.
    function automatic bit decode_byte(input logic [7:0] b, input logic start,
                                       output pixel_word_t word);
        int          size;
        logic [31:0] count;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        word = '0;
        if (start)
            restart_image();
        if (pixels_left == 32'd0)
            return 1'b0;

        if (cur_compressed && (want_header || packet_left == 8'd0))
        begin
            packet_left = {1'b0, b[6:0]} + 8'd1;
            packet_run = b[7];
            want_header = 1'b0;
            byte_pos = '0;
            held_bytes = '0;
            return 1'b0;
        end

        // The pixel size follows the live format, so a pixel may complete early.
        size = (cur_bpp >= tga_psd_pkg::BPP_555 && cur_bpp <= tga_psd_pkg::BPP_BGRA) ?
               int'(cur_bpp) : 1;
        if (int'(byte_pos) + 1 < size)
        begin
            held_bytes = held_bytes | 24'(32'(b) << (8 * byte_pos));
            byte_pos = byte_pos + 2'd1;
            return 1'b0;
        end

        b0 = held_bytes[7:0];
        b1 = held_bytes[15:8];
        b2 = held_bytes[23:16];
        case (cur_bpp)
            tga_psd_pkg::BPP_555:
            begin
                word.px.red   = {b[6:2], 3'b000};
                word.px.green = {b[1:0], b0[7:5], 3'b000};
                word.px.blue  = {b0[4:0], 3'b000};
                word.px.alpha = tga_psd_pkg::COMP_FULL;
            end
            tga_psd_pkg::BPP_BGR:
            begin
                word.px.red   = b;
                word.px.green = b1;
                word.px.blue  = b0;
                word.px.alpha = tga_psd_pkg::COMP_FULL;
            end
            tga_psd_pkg::BPP_BGRA:
            begin
                word.px.red   = b2;
                word.px.green = b1;
                word.px.blue  = b0;
                word.px.alpha = b;
            end
            default:
            begin
                word.px.red   = tga_psd_pkg::COMP_FULL;
                word.px.green = tga_psd_pkg::COMP_FULL;
                word.px.blue  = 8'h00;
                word.px.alpha = tga_psd_pkg::COMP_FULL;
            end
        endcase

        count = 32'd1;
        if (cur_compressed)
        begin
            if (packet_run)
            begin
                count = (32'(packet_left) > pixels_left) ? pixels_left : 32'(packet_left);
                packet_left = 8'd0;
            end
            else
                packet_left = packet_left - 8'd1;
            if (packet_left == 8'd0)
                want_header = 1'b1;
        end
        pixels_left = pixels_left - count;
        byte_pos = '0;
        held_bytes = '0;
        word.repeat_count = count[7:0];
        word.image_done = (pixels_left == 32'd0);
        return 1'b1;
    endfunction

    function void check_field(input string name, input logic [7:0] expected,
                              input logic [7:0] actual);
        if (actual !== expected)
        begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        pixel_word_t        want;
        pixel_word_t        next_word;
        tga_psd_pkg::rgba_t got_px;
        if (!rst_n)
        begin
            cur_compressed = tga_psd_pkg::RST_COMPRESSED_MODE;
            cur_bpp = tga_psd_pkg::RST_BYTES_PER_PIXEL;
            cur_total = tga_psd_pkg::RST_TOTAL_PIXELS;
            restart_image();
            expected_pixels.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (tga_psd_pkg::cfg_index_t'(cfg_index))
                    tga_psd_pkg::CFG_COMPRESSED_MODE: cur_compressed = cfg_data[0];
                    tga_psd_pkg::CFG_BYTES_PER_PIXEL: cur_bpp = cfg_data[2:0];
                    tga_psd_pkg::CFG_TOTAL_PIXELS:    cur_total = cfg_data;
                    default: ;
                endcase
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got_px = m_axis_tdata[31:0];
                if (expected_pixels.size() == 0)
                begin
                    $error("pixel word with nothing expected: tdata %h, tlast %b",
                           m_axis_tdata, m_axis_tlast);
                    fail_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("red", want.px.red, got_px.red);
                    check_field("green", want.px.green, got_px.green);
                    check_field("blue", want.px.blue, got_px.blue);
                    check_field("alpha", want.px.alpha, got_px.alpha);
                    check_field("repeat_count", want.repeat_count, m_axis_tdata[39:32]);
                    check_field("image_done", {7'd0, want.image_done},
                                {7'd0, m_axis_tlast});
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                if (decode_byte(s_axis_tdata, s_axis_tuser, next_word))
                    expected_pixels.push_back(next_word);

            if (end_of_run && !leftovers_checked)
            begin
                leftovers_checked = 1'b1;
                if (expected_pixels.size() != 0)
                begin
                    $error("%0d expected pixel words never arrived", expected_pixels.size());
                    fail_count++;
                end
            end
            pending = expected_pixels.size();
        end
    end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA pixel stream decoder testbench
// Feeds raw and run-length coded pixel bytes under several configurations,
// with random stalls on both streams, and lets the checker compare every
// pixel word against its own prediction.
// ----------------------------------------------------------------------------
module testbench;

    // Stimulus stops once this many bytes have been accepted.
    localparam int ITEM_TARGET     = 1100;
    // From here on neither side idles.
    localparam int QUIET_FROM      = 950;
    // The long receiver hold-off starts after this many bytes.
    localparam int PRESSURE_AT     = 300;
    localparam int PRESSURE_CYCLES = 150;
    // Cycles allowed after the last expected word before the block counts as idle.
    localparam int SETTLE_CYCLES   = 4;
    // Cycles with no word moving on any channel before the run is abandoned.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam logic [31:0] MAX_PIXELS = 32'hfffe0001;

    // Register select masks, one bit per configuration register.
    localparam logic [2:0] SET_MODE  = 3'(1 << tga_psd_pkg::CFG_COMPRESSED_MODE);
    localparam logic [2:0] SET_BPP   = 3'(1 << tga_psd_pkg::CFG_BYTES_PER_PIXEL);
    localparam logic [2:0] SET_TOTAL = 3'(1 << tga_psd_pkg::CFG_TOTAL_PIXELS);
    localparam logic [2:0] SET_ALL   = SET_MODE | SET_BPP | SET_TOTAL;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] data_byte
    logic        s_axis_tuser;     // [0] start_image
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;     // red, green, blue, alpha, repeat_count
    logic        m_axis_tlast;     // image_done

    int bytes_sent;
    int tx_gap_pct;
    int rx_stall_pct;
    int quiet_cycles;
    int fail_count;
    int pending;
    bit pressure_req;
    bit pressure_done;
    bit end_of_run;

    // What was last written to each register, used to shape well-formed images.
    logic        sh_comp;
    logic [2:0]  sh_bpp;
    logic [31:0] sh_total;

    tga_pixel_stream_decoder DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    tga_pixel_checker pixel_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .end_of_run    (end_of_run),
        .pending       (pending),
        .fail_count    (fail_count)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    // The watchdog only looks for progress: any word moving on any channel
    // restarts the count.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Pixel receiver. It stalls in random bursts while the stimulus allows it,
    // and once holds off for a long stretch so that the single output register
    // fills and the decoder pushes back on its input.
    initial
    begin : receiver
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (pressure_req && !pressure_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(negedge clk);
                pressure_done = 1'b1;
                m_axis_tready <= 1'b1;
            end
            else if (rx_stall_pct != 0 && $urandom_range(1, 100) <= rx_stall_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 8)) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Offers one byte and waits until it is accepted. tvalid is left high on
    // return, so back-to-back calls stream with no bubble; a random gap is
    // inserted first when the sender is allowed to idle.
    task automatic send_byte(input logic [7:0] data, input logic start);
        if (tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        s_axis_tuser <= start;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    // Drops the byte stream and waits until every predicted pixel word has
    // been taken, then gives the output register SETTLE_CYCLES to drain.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic put_reg(input tga_psd_pkg::cfg_index_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Writes the selected registers back to back; cfg_valid drops only after
    // the last one so that it is never lowered and raised in one time step.
    task automatic configure(input logic [2:0] which, input logic comp,
                             input logic [2:0] bpp, input logic [31:0] total);
        if (which[tga_psd_pkg::CFG_COMPRESSED_MODE])
        begin
            put_reg(tga_psd_pkg::CFG_COMPRESSED_MODE, {31'd0, comp});
            sh_comp = comp;
        end
        if (which[tga_psd_pkg::CFG_BYTES_PER_PIXEL])
        begin
            put_reg(tga_psd_pkg::CFG_BYTES_PER_PIXEL, {29'd0, bpp});
            sh_bpp = bpp;
        end
        if (which[tga_psd_pkg::CFG_TOTAL_PIXELS])
        begin
            put_reg(tga_psd_pkg::CFG_TOTAL_PIXELS, total);
            sh_total = total;
        end
        if (which != 3'b000)
            cfg_valid <= 1'b0;
    endtask

    // Sends one image that matches the last written configuration: a start
    // byte, then raw pixels or run and literal packets with random content.
    // Now and then the image is cut short or overruns its pixel count, and
    // packets of up to 128 pixels exercise run clipping at the image end.
    task automatic send_image();
        int   npix;
        int   left;
        int   cnt;
        int   n;
        int   size;
        int   k;
        logic run;
        logic first;
        size = (sh_bpp >= tga_psd_pkg::BPP_555 && sh_bpp <= tga_psd_pkg::BPP_BGRA) ?
               int'(sh_bpp) : 1;
        npix = (sh_total > 32'd24) ? int'($urandom_range(1, 40)) : int'(sh_total);
        case ($urandom_range(0, 9))
            0: npix = (npix > 1) ? int'($urandom_range(1, npix - 1)) : npix;
            1: npix = npix + 2;
            default: ;
        endcase
        // An image of zero pixels still gets a few bytes, all of them dropped.
        if (npix == 0)
            npix = 2;
        first = 1'b1;
        left = npix;
        while (left > 0)
        begin
            cnt = 1;
            n = 1;
            if (sh_comp)
            begin
                cnt = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 128))
                                                   : int'($urandom_range(1, 6));
                run = 1'($urandom_range(0, 1));
                send_byte({run, 7'(cnt - 1)}, first);
                first = 1'b0;
                // A run carries one pixel; a literal carries its pixels, but
                // never more than the image still needs plus the overrun.
                n = run ? 1 : ((cnt > left) ? left : cnt);
            end
            for (k = 0; k < n * size; k++)
            begin
                send_byte(8'($urandom), first);
                first = 1'b0;
            end
            left -= cnt;
        end
    endtask

    initial
    begin : stimulus
        logic [2:0] odd_formats [5];
        logic [2:0] mask;
        logic       comp;
        logic [2:0] bpp;
        logic [31:0] total;
        int         noise_len;

        odd_formats = '{3'd0, 3'd1, 3'd5, 3'd6, 3'd7};
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = tga_psd_pkg::CFG_COMPRESSED_MODE;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        bytes_sent = 0;
        sh_comp = tga_psd_pkg::RST_COMPRESSED_MODE;
        sh_bpp = tga_psd_pkg::RST_BYTES_PER_PIXEL;
        sh_total = tga_psd_pkg::RST_TOTAL_PIXELS;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset configuration: one raw BGRA pixel with extreme byte values,
        // then a byte past the end of the image that must be dropped.
        send_byte(8'hff, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h5a, 1'b0);
        wait_idle();

        // Run packets of 5-5-5 pixels: a run of two, then a run of 128 that
        // is clipped to the single pixel left in the image.
        configure(SET_ALL, 1'b1, tga_psd_pkg::BPP_555, 32'd3);
        send_byte({1'b1, 7'd1}, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte({1'b1, 7'h7f}, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        wait_idle();

        // A literal of six BGR pixels in an image of two: the bytes after
        // the last pixel are dropped.
        configure(SET_BPP | SET_TOTAL, 1'b1, tga_psd_pkg::BPP_BGR, 32'd2);
        send_byte({1'b0, 7'd5}, 1'b1);
        repeat (7) send_byte(8'($urandom), 1'b0);
        wait_idle();

        // An empty image decodes nothing, and an unsupported format turns
        // every byte into a fixed pixel.
        configure(SET_MODE | SET_TOTAL, 1'b0, tga_psd_pkg::BPP_BGR, 32'd0);
        send_byte(8'h33, 1'b1);
        wait_idle();
        configure(SET_BPP | SET_TOTAL, 1'b0, 3'd7, 32'd2);
        send_byte(8'hc3, 1'b1);
        send_byte(8'h3c, 1'b0);
        wait_idle();

        // Random phases. Each one may rewrite any of the registers while the
        // decoder is idle, then mostly sends well-formed images; the rest is
        // raw noise with scattered starts, which also carries an image across
        // a change of format or mode.
        while (bytes_sent < ITEM_TARGET)
        begin
            wait_idle();
            if (bytes_sent >= QUIET_FROM)
            begin
                tx_gap_pct = 0;
                rx_stall_pct = 0;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: tx_gap_pct = 0;
                    1: tx_gap_pct = 10;
                    default: tx_gap_pct = 35;
                endcase
                case ($urandom_range(0, 2))
                    0: rx_stall_pct = 0;
                    1: rx_stall_pct = 10;
                    default: rx_stall_pct = 35;
                endcase
            end

            comp = 1'($urandom_range(0, 1));
            bpp = ($urandom_range(0, 9) == 0) ? odd_formats[$urandom_range(0, 4)]
                                               : 3'($urandom_range(2, 4));
            case ($urandom_range(0, 19))
                0: total = 32'd0;
                1: total = MAX_PIXELS;
                2: total = $urandom;
                default: total = $urandom_range(1, 24);
            endcase
            mask = 3'($urandom_range(0, 7));
            configure(mask, comp, bpp, total);

            if (!pressure_req && bytes_sent >= PRESSURE_AT)
                pressure_req = 1'b1;

            if ($urandom_range(0, 5) == 0)
            begin
                noise_len = $urandom_range(4, 30);
                repeat (noise_len) send_byte(8'($urandom), $urandom_range(0, 11) == 0);
            end
            else
                repeat ($urandom_range(1, 3)) send_image();
        end

        wait_idle();
        end_of_run <= 1'b1;
        @(negedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- tga_pixel_stream_decoder.f -----
+incdir+rtl
rtl/tga_psd_pkg.sv
rtl/tga_psd_pixel_unpack.sv
rtl/tga_pixel_stream_decoder.sv
rtl/tga_psd_checker.sv
sim/tga_pixel_checker.sv
sim/testbench.sv
